>>> src/srsw_pkg.sv
// types and constants shared by the selective-repeat send window
package srsw_pkg;

	localparam int unsigned MaxChunk = 1012;

	typedef enum logic [2:0] {
		MODE_QUERY = 3'd0,
		MODE_ACK = 3'd1,
		MODE_FIN_ACK = 3'd2,
		MODE_OTHER = 3'd3,
		MODE_TICK = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DATA = 3'd0,
		KIND_RESEND = 3'd1,
		KIND_MARK = 3'd2,
		KIND_FIN = 3'd3,
		KIND_BAD = 3'd4
	} kind_t;

	localparam logic [1:0] CFG_WINDOW_MAX = 2'd0;
	localparam logic [1:0] CFG_CHUNK_BYTES = 2'd1;
	localparam logic [1:0] CFG_FIN_RETRY_LIMIT = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic file_ok;
		logic [31:0] file_bytes;
		logic [31:0] ack_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] seq_offset;
		logic [31:0] length;
		logic last;
	} result_t;

endpackage

>>> src/selective_repeat_send_window.sv
// top level: selective-repeat sender window kept in one entry memory
//
// channel   handshake                 payload
// command   start / busy              cmd   (srsw_pkg::cmd_t)
// result    result_valid strobe       result (srsw_pkg::result_t)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a command is latched in idle and decoded in dispatch; the ack search and the resend scan
// read each entry and then check it (registered read), and each refilled segment is written in fill
// each head pop moves every remaining entry down one slot with a read and a write per entry
// results go out one per cycle at most, with a strobe; the receiver cannot stall
// busy stays high until the last result of a command is out; reset clears
// all control state, the entry memory needs no clearing
module selective_repeat_send_window #(
	parameter int unsigned WINDOW_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input srsw_pkg::cmd_t cmd,
	output logic result_valid,
	output srsw_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import srsw_pkg::*;

	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACK_RD,
		ST_ACK_CMP,
		ST_POP_CHK_RD,
		ST_POP_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FILL,
		ST_FIN_CHK,
		ST_RES_RD,
		ST_RES_CHK
	} state_t;

	typedef struct packed {
		logic [31:0] off;
		logic [9:0] len;
		logic acked;
	} entry_t;

	// entry memory: one write, one read port, registered read
	entry_t mem [WINDOW_DEPTH];
	entry_t rd_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	entry_t wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	state_t state_q;
	logic [5:0] window_max_q;
	logic [9:0] chunk_bytes_q;
	logic [7:0] fin_retry_limit_q;
	cmd_t cmd_q;
	logic started_q, bad_file_q, finished_q, eof_seen_q;
	logic [31:0] next_offset_q, file_length_q;
	logic [CW-1:0] outstanding_q;
	logic [7:0] fin_retries_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pops_q;
	logic pend_valid_q;
	result_t pend_q;
	logic result_valid_q;
	result_t result_q;

	// effective window and chunk
	logic [CW-1:0] eff_win;
	logic [9:0] eff_chunk;
	logic [31:0] remain;
	logic [9:0] seg_len;
	cmd_t cmd_norm;
	logic out_fire;
	result_t out_data;

	always_comb begin
		if (window_max_q == 6'd0) begin
			eff_win = CW'(1);
		end else if (32'(window_max_q) > WINDOW_DEPTH) begin
			eff_win = CW'(WINDOW_DEPTH);
		end else begin
			eff_win = CW'(window_max_q);
		end
		if (chunk_bytes_q == 10'd0) begin
			eff_chunk = 10'd1;
		end else if (32'(chunk_bytes_q) > MaxChunk) begin
			eff_chunk = 10'(MaxChunk);
		end else begin
			eff_chunk = chunk_bytes_q;
		end
		remain = file_length_q - next_offset_q;
		seg_len = (remain < 32'(eff_chunk)) ? remain[9:0] : eff_chunk;
	end

	// unknown modes act as other packet
	always_comb begin
		cmd_norm = cmd;
		if (cmd.mode > MODE_TICK) begin
			cmd_norm.mode = MODE_OTHER;
		end
	end

	// held result goes out when a newer one replaces it, or with last when idle
	always_comb begin
		out_data = pend_q;
		case (state_q)
			ST_IDLE: begin
				out_fire = pend_valid_q;
				out_data.last = 1'b1;
			end
			ST_FILL: begin
				out_fire = pend_valid_q && outstanding_q < eff_win;
			end
			ST_FIN_CHK: begin
				out_fire = pend_valid_q && eof_seen_q && outstanding_q == '0;
			end
			ST_RES_CHK: begin
				out_fire = pend_valid_q && !rd_q.acked;
			end
			default: begin
				out_fire = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE) || pend_valid_q;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = '0;
		case (state_q)
			ST_ACK_RD, ST_RES_RD, ST_SHIFT_RD: begin
				rd_en = 1'b1;
			end
			ST_POP_CHK_RD: begin
				rd_en = 1'b1;
				rd_addr = '0;
			end
			ST_ACK_CMP: begin
				if (rd_q.off + 32'(rd_q.len) == cmd_q.ack_value) begin
					wr_en = 1'b1;
					wr_data = rd_q;
					wr_data.acked = 1'b1;
				end
			end
			ST_SHIFT_WR: begin
				wr_en = 1'b1;
				wr_addr = AW'(idx_q - CW'(1));
				wr_data = rd_q;
			end
			ST_FILL: begin
				if (outstanding_q < eff_win && next_offset_q < file_length_q) begin
					wr_en = 1'b1;
					wr_addr = outstanding_q[AW-1:0];
					wr_data.off = next_offset_q;
					wr_data.len = seg_len;
					wr_data.acked = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// one result is held back so that the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_max_q <= 6'd32;
			chunk_bytes_q <= 10'd1012;
			fin_retry_limit_q <= 8'd10;
			started_q <= 1'b0;
			bad_file_q <= 1'b0;
			finished_q <= 1'b0;
			eof_seen_q <= 1'b0;
			next_offset_q <= '0;
			file_length_q <= '0;
			outstanding_q <= '0;
			fin_retries_q <= '0;
			idx_q <= '0;
			pops_q <= '0;
			pend_valid_q <= 1'b0;
			pend_q <= '0;
			result_valid_q <= 1'b0;
			result_q <= '0;
			cmd_q <= '0;
		end else begin
			result_valid_q <= out_fire;
			if (out_fire) begin
				result_q <= out_data;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WINDOW_MAX: window_max_q <= cfg_data[5:0];
					CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[9:0];
					CFG_FIN_RETRY_LIMIT: fin_retry_limit_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (pend_valid_q) begin
						pend_valid_q <= 1'b0;
					end else if (start) begin
						cmd_q <= cmd_norm;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (finished_q) begin
						state_q <= ST_IDLE;
					end else if (cmd_q.mode == MODE_TICK) begin
						if (bad_file_q) begin
							finished_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if (started_q && outstanding_q != '0) begin
							idx_q <= '0;
							state_q <= ST_RES_RD;
						end else begin
							state_q <= ST_IDLE;
							if (started_q && eof_seen_q) begin
								pend_valid_q <= 1'b1;
								pend_q <= '{KIND_FIN, 32'd0, file_length_q, 1'b0};
								if (fin_retries_q >= fin_retry_limit_q) begin
									finished_q <= 1'b1;
								end else begin
									fin_retries_q <= fin_retries_q + 8'd1;
								end
							end
						end
					end else if (bad_file_q) begin
						pend_valid_q <= 1'b1;
						pend_q <= '{KIND_BAD, 32'd0, 32'd0, 1'b0};
						state_q <= ST_IDLE;
					end else if (cmd_q.mode == MODE_QUERY && !started_q) begin
						started_q <= 1'b1;
						if (!cmd_q.file_ok) begin
							bad_file_q <= 1'b1;
							pend_valid_q <= 1'b1;
							pend_q <= '{KIND_BAD, 32'd0, 32'd0, 1'b0};
							state_q <= ST_IDLE;
						end else begin
							file_length_q <= cmd_q.file_bytes;
							next_offset_q <= '0;
							outstanding_q <= '0;
							fin_retries_q <= '0;
							eof_seen_q <= (cmd_q.file_bytes == 32'd0);
							state_q <= ST_FILL;
						end
					end else if (cmd_q.mode == MODE_ACK && started_q) begin
						idx_q <= '0;
						state_q <= (outstanding_q != '0) ? ST_ACK_RD : ST_FIN_CHK;
					end else begin
						state_q <= ST_IDLE;
						if (cmd_q.mode == MODE_FIN_ACK && started_q) begin
							finished_q <= 1'b1;
						end
					end
				end
				ST_ACK_RD: begin
					state_q <= ST_ACK_CMP;
				end
				ST_ACK_CMP: begin
					if (rd_q.off + 32'(rd_q.len) == cmd_q.ack_value) begin
						pops_q <= '0;
						state_q <= ST_POP_CHK_RD;
					end else if (idx_q + CW'(1) < outstanding_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_ACK_RD;
					end else begin
						state_q <= ST_FIN_CHK;
					end
				end
				ST_POP_CHK_RD: begin
					state_q <= ST_POP_CHK;
				end
				ST_POP_CHK: begin
					// head acked: shift the remaining entries down by one
					if (outstanding_q != '0 && rd_q.acked) begin
						pops_q <= pops_q + CW'(1);
						idx_q <= CW'(1);
						if (outstanding_q > CW'(1)) begin
							state_q <= ST_SHIFT_RD;
						end else begin
							outstanding_q <= outstanding_q - CW'(1);
							state_q <= ST_POP_CHK_RD;
						end
					end else if (pops_q != '0 && outstanding_q < eff_win && !eof_seen_q) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_FIN_CHK;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					if (idx_q + CW'(1) < outstanding_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_SHIFT_RD;
					end else begin
						outstanding_q <= outstanding_q - CW'(1);
						state_q <= ST_POP_CHK_RD;
					end
				end
				ST_FILL: begin
					if (outstanding_q < eff_win) begin
						pend_valid_q <= 1'b1;
						if (next_offset_q < file_length_q) begin
							pend_q <= '{KIND_DATA, next_offset_q, 32'(seg_len), 1'b0};
							outstanding_q <= outstanding_q + CW'(1);
							next_offset_q <= next_offset_q + 32'(seg_len);
							if (next_offset_q + 32'(seg_len) == file_length_q) begin
								eof_seen_q <= 1'b1;
							end
						end else begin
							pend_q <= '{KIND_MARK, 32'd0, file_length_q, 1'b0};
							eof_seen_q <= 1'b1;
							state_q <= (cmd_q.mode == MODE_ACK) ? ST_FIN_CHK : ST_IDLE;
						end
					end else begin
						state_q <= (cmd_q.mode == MODE_ACK) ? ST_FIN_CHK : ST_IDLE;
					end
				end
				ST_FIN_CHK: begin
					if (eof_seen_q && outstanding_q == '0) begin
						pend_valid_q <= 1'b1;
						pend_q <= '{KIND_FIN, 32'd0, file_length_q, 1'b0};
					end
					state_q <= ST_IDLE;
				end
				ST_RES_RD: begin
					state_q <= ST_RES_CHK;
				end
				ST_RES_CHK: begin
					if (!rd_q.acked) begin
						pend_valid_q <= 1'b1;
						pend_q <= '{KIND_RESEND, rd_q.off, 32'(rd_q.len), 1'b0};
					end
					if (idx_q + CW'(1) < outstanding_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_RES_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CW'(WINDOW_DEPTH))
		else $error("window overflow");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && busy) |=> $stable(cmd_q) || state_q != ST_DISPATCH)
		else $error("command taken while busy");
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished cleared");
`endif

endmodule
